/* hw/rtl/three_phase_current_sense_macros.svh */
// ----------------------------------------------------------------------------
// Three-phase current sense assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_CURRENT_SENSE_MACROS_SVH
`define THREE_PHASE_CURRENT_SENSE_MACROS_SVH

`ifndef SYNTHESIS
`define TPCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TPCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TPCS_ASSERT_IMP(lbl, ante, cons, msg)
`define TPCS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/tpcs_pkg.sv */
// ----------------------------------------------------------------------------
// Three-phase current sense package
// Widths, register map and the frame record passed to the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcs_pkg;

  localparam int PHASES   = 3;
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int CUR_W    = 25;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

  // register index, taken from paddr[2]
  localparam logic REG_CURRENT_GAIN = 1'b0;

  // finished frame: sums of this frame and the bias in force at its end
  typedef struct packed {
    logic                          kind;
    logic [PHASES-1:0][SUM_W-1:0]  sum;
    logic [PHASES-1:0][SUM_W-1:0]  bias;
  } tpcs_frame_t;

endpackage

`default_nettype wire

/* hw/rtl/tpcs_scale.sv */
// ----------------------------------------------------------------------------
// Current scaler
// Per phase: product of (sum - bias) and gain, then negate, floor shift by 16
// and saturate into the output register; calibration frames (kind 0) give zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcs_scale (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire tpcs_pkg::tpcs_frame_t                        in_frame,
  input  wire logic [tpcs_pkg::GAIN_W-1:0]                  gain,
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic [tpcs_pkg::PHASES-1:0][tpcs_pkg::CUR_W-1:0]  current,
  output logic                                              was_cal
);

  localparam int DIFF_W = tpcs_pkg::SUM_W + 1;
  localparam int PROD_W = DIFF_W + tpcs_pkg::GAIN_W + 1;
  localparam int NEG_W  = PROD_W + 1;
  localparam int Q_W    = NEG_W - 16;
  localparam int CUR_W  = tpcs_pkg::CUR_W;

  logic                                              v2;
  logic                                              kind2;
  logic signed [tpcs_pkg::PHASES-1:0][PROD_W-1:0]    prod;
  logic signed [tpcs_pkg::PHASES-1:0][PROD_W-1:0]    prod_next;
  logic        [tpcs_pkg::PHASES-1:0][CUR_W-1:0]     current_next;
  logic                                              out_adv;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !v2 || out_adv;

  always_comb begin
    for (int p = 0; p < tpcs_pkg::PHASES; p++) begin
      logic signed [DIFF_W-1:0] diff;
      logic signed [PROD_W-1:0] diff_x;
      logic signed [PROD_W-1:0] gain_x;
      diff   = signed'({1'b0, in_frame.sum[p]}) - signed'({1'b0, in_frame.bias[p]});
      diff_x = PROD_W'(diff);
      gain_x = signed'({{(PROD_W - tpcs_pkg::GAIN_W){1'b0}}, gain});
      prod_next[p] = diff_x * gain_x;
    end
  end

  always_comb begin
    for (int p = 0; p < tpcs_pkg::PHASES; p++) begin
      logic signed [NEG_W-1:0] neg;
      logic signed [Q_W-1:0]   q;
      neg = -NEG_W'(signed'(prod[p]));
      // arithmetic shift: floor division by 2^16
      q = neg[NEG_W-1:16];
      if (kind2 == 1'b0) begin
        current_next[p] = '0;
      end else if (q[Q_W-1:CUR_W-1] != '0 && q[Q_W-1:CUR_W-1] != '1) begin
        current_next[p] = q[Q_W-1] ? {1'b1, {(CUR_W-1){1'b0}}} : {1'b0, {(CUR_W-1){1'b1}}};
      end else begin
        current_next[p] = q[CUR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v2 <= in_valid;
      end
      if (out_adv) begin
        out_valid <= v2;
      end
    end
    if (in_ready && in_valid) begin
      prod  <= prod_next;
      kind2 <= in_frame.kind;
    end
    if (out_adv && v2) begin
      current <= current_next;
      was_cal <= !kind2;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/three_phase_current_sense.sv */
// Output: m_tvalid rises once a frame's last sample has passed the frame register,
//   the gain product register and the output register, in that order.
// Throughput: one sample per cycle while s_tready is high; one result per FRAME_LEN samples.
// Reset (synchronous, rst high): frame position, sums, bias, frame kind and all
//   valid flags clear; current_gain returns to 65536.
// ----------------------------------------------------------------------------
// Three-phase current sense
// Frame accumulation with bias calibration, gain scaling and APB gain register.
// ----------------------------------------------------------------------------
`default_nettype none

module three_phase_current_sense #(
  parameter int FRAME_LEN = 16,
  parameter int SKIP      = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // sample_a[11:0], sample_b[23:12], sample_c[35:24]
  input  wire logic [0:0]  s_tuser,   // kind[0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // current_a[24:0], current_b[49:25], current_c[74:50]
  output logic [0:0]       m_tuser    // was_calibration[0]
);

  `include "three_phase_current_sense_macros.svh"

  localparam int POS_W    = $clog2(FRAME_LEN);
  localparam int PHASES   = tpcs_pkg::PHASES;
  localparam int SUM_W    = tpcs_pkg::SUM_W;
  localparam int SAMPLE_W = tpcs_pkg::SAMPLE_W;

  logic [tpcs_pkg::GAIN_W-1:0]          current_gain;
  logic [POS_W-1:0]                     pos;
  logic [PHASES-1:0][SUM_W-1:0]         frame_sums;
  logic [PHASES-1:0][SUM_W-1:0]         frame_sums_next;
  logic [PHASES-1:0][SUM_W-1:0]         bias_sums;
  logic                                 frame_kind;
  logic                                 kind_next;
  logic                                 s_accept;
  logic                                 last;
  logic                                 counted;
  logic                                 v1;
  tpcs_pkg::tpcs_frame_t                frame1;
  logic                                 frame_ready;
  logic [PHASES-1:0][tpcs_pkg::CUR_W-1:0] current;
  logic                                 was_cal;

  // configuration
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      tpcs_pkg::REG_CURRENT_GAIN: prdata = {{(32 - tpcs_pkg::GAIN_W){1'b0}}, current_gain};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_gain <= tpcs_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == tpcs_pkg::REG_CURRENT_GAIN) begin
      current_gain <= pwdata[tpcs_pkg::GAIN_W-1:0];
    end
  end

  // accumulation
  assign s_tready = !v1 || frame_ready;
  assign s_accept = s_tvalid && s_tready;
  assign last     = pos == POS_W'(FRAME_LEN - 1);
  assign counted  = 32'(pos) >= SKIP;
  assign kind_next = (pos == '0) ? s_tuser[0] : frame_kind;

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      logic [SUM_W-1:0] base;
      logic [SUM_W:0]   total;
      base  = (pos == '0) ? '0 : frame_sums[p];
      total = {1'b0, base} + (SUM_W + 1)'(s_tdata[p*SAMPLE_W +: SAMPLE_W]);
      if (!counted) begin
        frame_sums_next[p] = base;
      end else begin
        frame_sums_next[p] = total[SUM_W] ? '1 : total[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      frame_sums <= '0;
      bias_sums  <= '0;
      frame_kind <= 1'b0;
      v1         <= 1'b0;
    end else begin
      if (s_accept) begin
        pos        <= last ? '0 : pos + POS_W'(1);
        frame_sums <= frame_sums_next;
        frame_kind <= kind_next;
        if (last && kind_next == 1'b0) begin
          bias_sums <= frame_sums_next;
        end
      end
      if (s_accept && last) begin
        v1 <= 1'b1;
      end else if (frame_ready) begin
        v1 <= 1'b0;
      end
    end
    if (s_accept && last) begin
      frame1.kind <= kind_next;
      frame1.sum  <= frame_sums_next;
      frame1.bias <= bias_sums;
    end
  end

  tpcs_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (frame_ready),
    .in_frame  (frame1),
    .gain      (current_gain),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .current   (current),
    .was_cal   (was_cal)
  );

  assign m_tdata = {5'b0, current[2], current[1], current[0]};
  assign m_tuser = was_cal;

  `TPCS_ASSERT_NXT(a_last_loads_frame, s_accept && last, v1, "frame end not registered")
  `TPCS_ASSERT_NXT(a_pos_wraps, s_accept && last, pos == '0, "position did not wrap")
  `TPCS_ASSERT_NXT(a_no_spurious_frame, s_accept && !last && !v1, !v1,
                   "frame registered mid-frame")
  `TPCS_ASSERT_IMP(a_cal_zero, m_tvalid && m_tuser[0], m_tdata == '0,
                   "calibration result not zero")

endmodule

`default_nettype wire
